>>> src/pfk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_pkg
// Shared types and constants of the planar arm forward kinematics block.
// ----------------------------------------------------------------------------
package pfk_pkg;

  localparam int ANGLE_W = 17;
  localparam int FS_W    = 10;
  localparam int LEN_W   = 16;
  localparam int CW      = 34;
  localparam int OUT_W   = 17;
  localparam int CFG_W   = 17;
  localparam int IDX_W   = 3;
  localparam int TURN    = 92160;

  localparam logic [IDX_W-1:0] REG_COUNT_AT_ZERO  = 3'd0;
  localparam logic [IDX_W-1:0] REG_COUNT_AT_FULL  = 3'd1;
  localparam logic [IDX_W-1:0] REG_FULL_SCALE_DEG = 3'd2;
  localparam logic [IDX_W-1:0] REG_FIRST_LEN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_SECOND_LEN     = 3'd4;
  localparam logic [IDX_W-1:0] REG_THIRD_LEN      = 3'd5;
  localparam logic [IDX_W-1:0] REG_BASE_HEIGHT    = 3'd6;
  localparam logic [IDX_W-1:0] REG_SHOULDER_OFS   = 3'd7;

  localparam logic signed [CW-1:0] QUARTER_BIN = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF_BIN    = 34'sd2147483648;
  localparam logic signed [CW-1:0] CORDIC_X0   = 34'sd652032874;

  localparam int ATAN_ENTRIES = 24;
  localparam logic [31:0] ATAN_BIN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic [11:0]     zero;
    logic [11:0]     full;
    logic [FS_W-1:0] fs;
  } scale_t;

  typedef struct packed {
    logic [LEN_W-1:0] first_len;
    logic [LEN_W-1:0] second_len;
    logic [LEN_W-1:0] third_len;
    logic [LEN_W-1:0] base;
  } geom_t;

endpackage

>>> src/pfk_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_in_if
// Joint count channel: valid, ready and three raw joint counts.
// ----------------------------------------------------------------------------
interface pfk_in_if #(parameter int COUNT_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] first_joint_count;
  logic [COUNT_BITS-1:0] second_joint_count;
  logic [COUNT_BITS-1:0] third_joint_count;

  modport source (output valid, output first_joint_count, output second_joint_count,
                  output third_joint_count, input ready);
  modport sink (input valid, input first_joint_count, input second_joint_count,
                input third_joint_count, output ready);
endinterface

>>> src/pfk_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_out_if
// Tip position channel: valid, ready and signed Q16 x and y.
// ----------------------------------------------------------------------------
interface pfk_out_if ();
  import pfk_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] tip_x;
  logic signed [OUT_W-1:0] tip_y;

  modport source (output valid, output tip_x, output tip_y, input ready);
  modport sink (input valid, input tip_x, input tip_y, output ready);
endinterface

>>> src/planar_arm_forward_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics
// Gripper position of a planar three-link arm from three joint counts.
//
// in_word carries three raw joint counts; out_word returns tip_x and tip_y,
// signed metres in Q16. The cfg_ port writes scaling, link lengths, base
// height and shoulder offset; write it only while no word is in flight.
// Three joint lanes scale the counts through a pipelined divider, one
// quotient bit per stage; three CORDIC lanes form cos and sin one rotation
// per stage; a merge block weights, sums, rounds and saturates.
// Throughput: one word per cycle while the receiver takes every word.
// The whole pipeline advances together: while out_word holds a word that the
// receiver does not take, every stage holds and in_word.ready is low.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module planar_arm_forward_kinematics #(
  parameter int COUNT_BITS   = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pfk_in_if.sink                      in_word,
  pfk_out_if.source                   out_word,
  input  logic                        cfg_we,
  input  logic [pfk_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pfk_pkg::CFG_W-1:0]   cfg_data
);
  import pfk_pkg::*;

  localparam int QW  = COUNT_BITS + FS_W + 8;
  localparam int LAT = (QW + 2) + 1 + (CORDIC_STEPS + 5) + 2;
  localparam logic signed [19:0] TURN20  = 20'sd92160;
  localparam logic signed [19:0] RIGHT20 = 20'sd23040;
  localparam logic signed [19:0] HALF20  = 20'sd46080;
  localparam logic [ANGLE_W-1:0] TURN_A  = ANGLE_W'(TURN);

  logic [11:0]        zero_r, full_r;
  logic [FS_W-1:0]    fs_r;
  logic [LEN_W-1:0]   len1_r, len2_r, len3_r, base_r;
  logic [ANGLE_W-1:0] ofs_r;

  scale_t             scale;
  geom_t              geom;
  logic               en, in_acc;
  logic [LAT-1:0]     vld_r;

  logic [ANGLE_W-1:0] ang [3];
  logic [ANGLE_W-1:0] ofs_w;
  logic signed [19:0] sa, sb, sg, so, t1s, t2s, t3s;
  logic [ANGLE_W-1:0] t1, t2, t3;
  logic [ANGLE_W-1:0] dir_r [3];
  logic signed [CW-1:0] cs [3];
  logic signed [CW-1:0] sn [3];
  logic [COUNT_BITS-1:0] cnt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= 12'd0;
      full_r <= 12'd4095;
      fs_r   <= 10'd360;
      len1_r <= 16'd8535;
      len2_r <= 16'd8127;
      len3_r <= 16'd8258;
      base_r <= 16'd5046;
      ofs_r  <= 17'd20321;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_AT_ZERO:  zero_r <= cfg_data[11:0];
        REG_COUNT_AT_FULL:  full_r <= cfg_data[11:0];
        REG_FULL_SCALE_DEG: fs_r   <= cfg_data[FS_W-1:0];
        REG_FIRST_LEN:      len1_r <= cfg_data[LEN_W-1:0];
        REG_SECOND_LEN:     len2_r <= cfg_data[LEN_W-1:0];
        REG_THIRD_LEN:      len3_r <= cfg_data[LEN_W-1:0];
        REG_BASE_HEIGHT:    base_r <= cfg_data[LEN_W-1:0];
        REG_SHOULDER_OFS:   ofs_r  <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign scale = '{zero: zero_r, full: full_r, fs: fs_r};
  assign geom  = '{first_len: len1_r, second_len: len2_r, third_len: len3_r, base: base_r};

  assign out_word.valid = vld_r[LAT-1];
  assign en             = !vld_r[LAT-1] || out_word.ready;
  assign in_word.ready  = en;
  assign in_acc         = in_word.valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_acc};
    end
  end

  assign cnt[0] = in_word.first_joint_count;
  assign cnt[1] = in_word.second_joint_count;
  assign cnt[2] = in_word.third_joint_count;

  for (genvar k = 0; k < 3; k++) begin : g_joint
    pfk_joint_lane #(.COUNT_BITS(COUNT_BITS)) u_joint (
      .clk   (clk),
      .en    (en),
      .count (cnt[k]),
      .scale (scale),
      .angle (ang[k])
    );
  end

  assign ofs_w = (ofs_r >= TURN_A) ? ofs_r - TURN_A : ofs_r;
  assign sa    = 20'(ang[0]);
  assign sb    = 20'(ang[1]);
  assign sg    = 20'(ang[2]);
  assign so    = 20'(ofs_w);
  assign t1s   = sa - so;
  assign t2s   = sa + sb - RIGHT20;
  assign t3s   = sg - sb - sa + HALF20;

  always_comb begin
    t1 = (t1s < 0) ? ANGLE_W'(t1s + TURN20) : ANGLE_W'(t1s);
    if (t2s < 0) begin
      t2 = ANGLE_W'(t2s + TURN20);
    end else if (t2s >= TURN20) begin
      t2 = ANGLE_W'(t2s - TURN20);
    end else begin
      t2 = ANGLE_W'(t2s);
    end
    if (t3s < -TURN20) begin
      t3 = ANGLE_W'(t3s + TURN20 + TURN20);
    end else if (t3s < 0) begin
      t3 = ANGLE_W'(t3s + TURN20);
    end else if (t3s >= TURN20) begin
      t3 = ANGLE_W'(t3s - TURN20);
    end else begin
      t3 = ANGLE_W'(t3s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r[0] <= t1;
      dir_r[1] <= t2;
      dir_r[2] <= t3;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cordic
    pfk_cordic_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clk   (clk),
      .en    (en),
      .dir   (dir_r[k]),
      .cos_o (cs[k]),
      .sin_o (sn[k])
    );
  end

  pfk_merge u_merge (
    .clk   (clk),
    .en    (en),
    .geom  (geom),
    .cos_i (cs),
    .sin_i (sn),
    .tip_x (out_word.tip_x),
    .tip_y (out_word.tip_y)
  );

endmodule

>>> src/pfk_joint_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_joint_lane
// Scales one joint count to an angle in 1/256 degree, wrapped to one turn,
// through a pipelined restoring divider that also reduces the quotient.
// ----------------------------------------------------------------------------
module pfk_joint_lane #(
  parameter int COUNT_BITS = 12
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [COUNT_BITS-1:0]         count,
  input  pfk_pkg::scale_t               scale,
  output logic [pfk_pkg::ANGLE_W-1:0]   angle
);
  import pfk_pkg::*;

  localparam int QW = COUNT_BITS + FS_W + 8;
  localparam logic [ANGLE_W:0]   TURN_Q = (ANGLE_W+1)'(TURN);
  localparam logic [ANGLE_W-1:0] TURN_A = ANGLE_W'(TURN);

  logic [COUNT_BITS-1:0] zc, fc, den_mag, num_mag;
  logic                  den_neg, den_zero, num_neg;
  logic [QW-1:0]         num_full;

  logic [QW-1:0]         num_r  [0:QW];
  logic [COUNT_BITS-1:0] rem_r  [0:QW];
  logic [ANGLE_W-1:0]    qm_r   [0:QW];
  logic                  sgn_r  [0:QW];
  logic                  zero_r [0:QW];
  logic [ANGLE_W-1:0]    angle_r;

  assign zc       = COUNT_BITS'(scale.zero);
  assign fc       = COUNT_BITS'(scale.full);
  assign den_neg  = fc < zc;
  assign den_mag  = den_neg ? zc - fc : fc - zc;
  assign den_zero = fc == zc;
  assign num_neg  = count < zc;
  assign num_mag  = num_neg ? zc - count : count - zc;
  assign num_full = (QW'(num_mag) * QW'(scale.fs)) << 8;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r[0]  <= num_full;
      rem_r[0]  <= '0;
      qm_r[0]   <= '0;
      sgn_r[0]  <= num_neg ^ den_neg;
      zero_r[0] <= den_zero;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [COUNT_BITS:0]   sh, df;
    logic                  ge;
    logic [ANGLE_W:0]      q2;
    logic [ANGLE_W-1:0]    qn;
    logic [COUNT_BITS-1:0] nrem;

    assign sh   = {rem_r[j], num_r[j][QW-1]};
    assign df   = sh - {1'b0, den_mag};
    assign ge   = sh >= {1'b0, den_mag};
    assign nrem = ge ? df[COUNT_BITS-1:0] : sh[COUNT_BITS-1:0];
    assign q2   = {qm_r[j], 1'b0} + (ANGLE_W+1)'(ge);
    assign qn   = (q2 >= TURN_Q) ? ANGLE_W'(q2 - TURN_Q) : q2[ANGLE_W-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[j+1]  <= num_r[j] << 1;
        rem_r[j+1]  <= nrem;
        qm_r[j+1]   <= qn;
        sgn_r[j+1]  <= sgn_r[j];
        zero_r[j+1] <= zero_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[QW]) begin
        angle_r <= '0;
      end else if (sgn_r[QW] && qm_r[QW] != '0) begin
        angle_r <= TURN_A - qm_r[QW];
      end else begin
        angle_r <= qm_r[QW];
      end
    end
  end

  assign angle = angle_r;

endmodule

>>> src/pfk_cordic_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_cordic_lane
// Converts a direction in 1/256 degree to a binary angle, folds it to the
// right half plane and runs a pipelined rotation CORDIC for cos and sin.
// ----------------------------------------------------------------------------
module pfk_cordic_lane #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [pfk_pkg::ANGLE_W-1:0]       dir,
  output logic signed [pfk_pkg::CW-1:0]     cos_o,
  output logic signed [pfk_pkg::CW-1:0]     sin_o
);
  import pfk_pkg::*;

  localparam logic [34:0] RECIP45   = 35'd186414;
  localparam logic [16:0] DIV45     = 17'd45;
  localparam logic [9:0]  ROUND_ADD = 10'd22;
  localparam logic [20:0] RECIP45_S = 21'd1457;
  localparam logic [21:0] STEP_FRAC = 22'd46603;

  logic [34:0]        prod;
  logic [10:0]        k_a_r, k_b_r, k_c_r;
  logic [ANGLE_W-1:0] d_a_r;
  logic [ANGLE_W-1:0] m_full;
  logic [5:0]         m_b_r;
  logic [9:0]         yv;
  logic [20:0]        yq_full;
  logic [20:0]        frac;
  logic [20:0]        frac_r;
  logic signed [CW-1:0] z0, zf;
  logic                 negf;

  logic signed [CW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] z_r [0:CORDIC_STEPS];
  logic                 neg_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cos_r, sin_r;

  assign prod = 35'(dir) * RECIP45;

  always_ff @(posedge clk) begin
    if (en) begin
      k_a_r <= prod[33:23];
      d_a_r <= dir;
    end
  end

  assign m_full = d_a_r - 17'(k_a_r) * DIV45;

  always_ff @(posedge clk) begin
    if (en) begin
      k_b_r <= k_a_r;
      m_b_r <= m_full[5:0];
    end
  end

  assign yv      = {m_b_r, 4'b0000} + 10'(m_b_r) + ROUND_ADD;
  assign yq_full = 21'(yv) * RECIP45_S;
  assign frac    = 21'(22'(m_b_r) * STEP_FRAC) + 21'(yq_full[20:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      k_c_r  <= k_b_r;
      frac_r <= frac;
    end
  end

  assign z0 = CW'($signed({k_c_r, frac_r}));

  always_comb begin
    zf   = z0;
    negf = 1'b0;
    if (z0 > QUARTER_BIN) begin
      zf   = z0 - HALF_BIN;
      negf = 1'b1;
    end else if (z0 < -QUARTER_BIN) begin
      zf   = z0 + HALF_BIN;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= CORDIC_X0;
      y_r[0]   <= '0;
      z_r[0]   <= zf;
      neg_r[0] <= negf;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] dx, dy, da;

    assign dx = x_r[i] >>> 0;
    assign dy = y_r[i] >>> i;
    assign da = CW'($signed({1'b0, ATAN_BIN[i]}));

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + (dx >>> i);
          z_r[i+1] <= z_r[i] - da;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - (dx >>> i);
          z_r[i+1] <= z_r[i] + da;
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_r <= neg_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

>>> src/pfk_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_merge
// Weights each lane's cos and sin by its link length, sums the lanes, adds
// the base height to y, rounds to Q16 and saturates into the output word.
// ----------------------------------------------------------------------------
module pfk_merge (
  input  logic                             clk,
  input  logic                             en,
  input  pfk_pkg::geom_t                   geom,
  input  logic signed [pfk_pkg::CW-1:0]    cos_i [3],
  input  logic signed [pfk_pkg::CW-1:0]    sin_i [3],
  output logic signed [pfk_pkg::OUT_W-1:0] tip_x,
  output logic signed [pfk_pkg::OUT_W-1:0] tip_y
);
  import pfk_pkg::*;

  localparam int PW = CW + LEN_W + 1;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0]    HALF_LSB = SW'(64'sd536870912);
  localparam logic signed [SW-31:0]   SAT_HI   = (SW-30)'(65535);
  localparam logic signed [SW-31:0]   SAT_LO   = -(SW-30)'(65536);

  logic [LEN_W-1:0]     len [3];
  logic signed [PW-1:0] px_r [3];
  logic signed [PW-1:0] py_r [3];
  logic signed [SW-1:0] sx, sy;
  logic signed [SW-31:0] vx, vy;
  logic signed [OUT_W-1:0] tip_x_r, tip_y_r;

  assign len[0] = geom.first_len;
  assign len[1] = geom.second_len;
  assign len[2] = geom.third_len;

  for (genvar k = 0; k < 3; k++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        px_r[k] <= PW'($signed({1'b0, len[k]})) * PW'(cos_i[k]);
        py_r[k] <= PW'($signed({1'b0, len[k]})) * PW'(sin_i[k]);
      end
    end
  end

  assign sx = SW'(px_r[0]) + SW'(px_r[1]) + SW'(px_r[2]) + HALF_LSB;
  assign sy = SW'(py_r[0]) + SW'(py_r[1]) + SW'(py_r[2]) + HALF_LSB
            + (SW'($signed({1'b0, geom.base})) <<< 30);
  assign vx = sx[SW-1:30];
  assign vy = sy[SW-1:30];

  always_ff @(posedge clk) begin
    if (en) begin
      tip_x_r <= (vx > SAT_HI) ? OUT_W'(SAT_HI) : (vx < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(vx);
      tip_y_r <= (vy > SAT_HI) ? OUT_W'(SAT_HI) : (vy < SAT_LO) ? OUT_W'(SAT_LO) : OUT_W'(vy);
    end
  end

  assign tip_x = tip_x_r;
  assign tip_y = tip_y_r;

endmodule

>>> src/pfk_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_chk
// Port-level checks of the planar arm forward kinematics block.
// ----------------------------------------------------------------------------
module pfk_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pfk_pkg::OUT_W-1:0]  tip_x,
  input logic signed [pfk_pkg::OUT_W-1:0]  tip_y
);
  import pfk_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not track output drain");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(tip_x) && $stable(tip_y))
    else $error("output word changed while stalled");

endmodule

bind planar_arm_forward_kinematics pfk_chk u_pfk_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .tip_x     (out_word.tip_x),
  .tip_y     (out_word.tip_y)
);

>>> tb/pfk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfk_checker
// Tip position scoreboard for the planar arm forward kinematics block.
//
// Watches the joint count, tip position and register write ports. It keeps
// its own copy of the registers and computes the tip position of every
// accepted joint word. Each returned tip word is compared, field by field,
// with the oldest predicted position.
// ----------------------------------------------------------------------------
module pfk_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  pfk_in_if                         in_mon,
  pfk_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [pfk_pkg::IDX_W-1:0] cfg_index,
  input  logic [pfk_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import pfk_pkg::*;

  localparam longint FULL_TURN_BIN = 64'sd4294967296;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } tip_pos_t;

  logic [11:0]      zero_cnt;
  logic [11:0]      full_cnt;
  logic [FS_W-1:0]  fs_deg;
  logic [LEN_W-1:0] len1;
  logic [LEN_W-1:0] len2;
  logic [LEN_W-1:0] len3;
  logic [LEN_W-1:0] base_h;
  logic [16:0]      shoulder_ofs;

  tip_pos_t tip_queue[$];

  assign pending = tip_queue.size();

  function automatic longint wrap_turn(longint v);
    longint r;
    r = v % TURN;
    if (r < 0) r += TURN;
    return r;
  endfunction

  function automatic longint joint_angle(logic [11:0] c);
    longint den;
    den = longint'(full_cnt) - longint'(zero_cnt);
    if (den == 0) return 0;
    return wrap_turn(((longint'(c) - longint'(zero_cnt)) * longint'(fs_deg) * 256) / den);
  endfunction

  task automatic cordic_cos_sin(input longint d, output longint co, output longint si);
    logic [63:0] b;
    longint z, x, y, dx, dy;
    bit neg;
    b = ((64'(d) << 32) + 64'(TURN / 2)) / 64'(TURN);
    z = longint'({32'b0, b[31:0]});
    neg = 0;
    x = longint'(CORDIC_X0);
    y = 0;
    if (z >= longint'(HALF_BIN)) z -= FULL_TURN_BIN;
    if (z > longint'(QUARTER_BIN)) begin
      z -= longint'(HALF_BIN);
      neg = 1;
    end else if (z < -longint'(QUARTER_BIN)) begin
      z += longint'(HALF_BIN);
      neg = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_BIN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_BIN[i]);
      end
    end
    co = neg ? -x : x;
    si = neg ? -y : y;
  endtask

  function automatic logic signed [OUT_W-1:0] round_sat(longint s);
    longint v;
    v = (s + (64'sd1 <<< 29)) >>> 30;
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[OUT_W-1:0];
  endfunction

  task automatic predict_tip(input logic [11:0] c1, input logic [11:0] c2,
                             input logic [11:0] c3, output tip_pos_t p);
    longint a, b, g, co1, si1, co2, si2, co3, si3, sx, sy;
    a = joint_angle(c1);
    b = joint_angle(c2);
    g = joint_angle(c3);
    cordic_cos_sin(wrap_turn(a - longint'(shoulder_ofs)), co1, si1);
    cordic_cos_sin(wrap_turn(a + b - 90 * 256), co2, si2);
    cordic_cos_sin(wrap_turn(g - b - a + 180 * 256), co3, si3);
    sx = longint'(len1) * co1 + longint'(len2) * co2 + longint'(len3) * co3;
    sy = longint'(len1) * si1 + longint'(len2) * si2 + longint'(len3) * si3
       + (longint'(base_h) <<< 30);
    p.x = round_sat(sx);
    p.y = round_sat(sy);
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    tip_pos_t p;
    if (!rst_n) begin
      zero_cnt     = 12'd0;
      full_cnt     = 12'd4095;
      fs_deg       = 10'd360;
      len1         = 16'd8535;
      len2         = 16'd8127;
      len3         = 16'd8258;
      base_h       = 16'd5046;
      shoulder_ofs = 17'd20321;
      tip_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNT_AT_ZERO:  zero_cnt = cfg_data[11:0];
          REG_COUNT_AT_FULL:  full_cnt = cfg_data[11:0];
          REG_FULL_SCALE_DEG: fs_deg = cfg_data[FS_W-1:0];
          REG_FIRST_LEN:      len1 = cfg_data[LEN_W-1:0];
          REG_SECOND_LEN:     len2 = cfg_data[LEN_W-1:0];
          REG_THIRD_LEN:      len3 = cfg_data[LEN_W-1:0];
          REG_BASE_HEIGHT:    base_h = cfg_data[LEN_W-1:0];
          REG_SHOULDER_OFS:   shoulder_ofs = cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (tip_queue.size() == 0) begin
          $display("%0t mismatch: tip word with no prediction", $realtime);
          fail_count++;
        end else begin
          p = tip_queue.pop_front();
          if (out_mon.tip_x !== p.x) report("tip_x", out_mon.tip_x, p.x);
          if (out_mon.tip_y !== p.y) report("tip_y", out_mon.tip_y, p.y);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_tip(in_mon.first_joint_count, in_mon.second_joint_count,
                    in_mon.third_joint_count, p);
        tip_queue.push_back(p);
      end
    end
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the planar arm forward kinematics block.
//
// Resets the block, then runs phases of joint words under several register
// settings: defaults, count interval extremes, empty and reversed intervals,
// saturating link lengths and random settings. The sender works in bursts,
// the receiver stalls on its own pattern, including one long hold-off that
// backs up the pipeline. The checker predicts and compares every tip word.
// ----------------------------------------------------------------------------
module tb_top;
  import pfk_pkg::*;

  localparam int LATENCY  = 56;
  localparam int WATCHDOG = 20000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               idle_cycles;
  bit               hold_req;

  pfk_in_if #(.COUNT_BITS(12)) in_ch ();
  pfk_out_if                   out_ch ();

  planar_arm_forward_kinematics #(.COUNT_BITS(12), .CORDIC_STEPS(16)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pfk_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: stall pattern, with one long hold-off on request
  initial begin
    int mode;
    int left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  int burst_left;

  task automatic send_word(input logic [11:0] c1, input logic [11:0] c2,
                           input logic [11:0] c3);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid              <= 1'b1;
    in_ch.first_joint_count  <= c1;
    in_ch.second_joint_count <= c2;
    in_ch.third_joint_count  <= c3;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_scale(input int zero, input int full, input int fs);
    write_reg(REG_COUNT_AT_ZERO, zero);
    write_reg(REG_COUNT_AT_FULL, full);
    write_reg(REG_FULL_SCALE_DEG, fs);
  endtask

  task automatic set_geometry(input int l1, input int l2, input int l3,
                              input int bh, input int ofs);
    write_reg(REG_FIRST_LEN, l1);
    write_reg(REG_SECOND_LEN, l2);
    write_reg(REG_THIRD_LEN, l3);
    write_reg(REG_BASE_HEIGHT, bh);
    write_reg(REG_SHOULDER_OFS, ofs);
  endtask

  task automatic random_words(input int n);
    repeat (n) send_word(12'($urandom), 12'($urandom), 12'($urandom));
  endtask

  task automatic directed_words();
    send_word(12'd0, 12'd0, 12'd0);
    send_word(12'hFFF, 12'hFFF, 12'hFFF);
    send_word(12'h000, 12'hFFF, 12'h000);
    send_word(12'hFFF, 12'h000, 12'hFFF);
    send_word(12'd1024, 12'd2048, 12'd3072);
    send_word(12'd2048, 12'd1024, 12'd512);
    send_word(12'hAAA, 12'h555, 12'hAAA);
    send_word(12'h555, 12'hAAA, 12'h555);
    send_word(12'd1, 12'd4094, 12'd2047);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    hold_req    = 0;
    idle_cycles = 0;
    burst_left  = 0;
    in_ch.valid = 1'b0;
    in_ch.first_joint_count  = '0;
    in_ch.second_joint_count = '0;
    in_ch.third_joint_count  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_words();
    random_words(60);
    drain();

    // widest scale, longest links, extreme offset
    set_scale(0, 4095, 720);
    set_geometry(65535, 65535, 65535, 65535, 92159);
    directed_words();
    drain();

    // empty count interval
    set_scale(2000, 2000, 360);
    set_geometry(0, 0, 0, 0, 0);
    send_word(12'd0, 12'd2000, 12'hFFF);
    drain();
    set_geometry(30000, 20000, 10000, 1000, 131071);
    set_scale(2000, 2000, 360);
    send_word(12'd0, 12'd2000, 12'hFFF);
    drain();

    // reversed interval
    set_scale(4095, 1, 1);
    set_geometry(65535, 0, 65535, 0, 46080);
    directed_words();
    drain();

    // long receiver hold-off while words keep coming
    set_scale(0, 4095, 360);
    set_geometry(8535, 8127, 8258, 5046, 20321);
    hold_req = 1;
    random_words(150);
    drain();

    repeat (5) begin
      set_scale($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 1023));
      if ($urandom_range(0, 1)) begin
        set_geometry($urandom_range(0, 20000), $urandom_range(0, 20000),
                     $urandom_range(0, 20000), $urandom_range(0, 20000),
                     $urandom_range(0, 92159));
      end else begin
        set_geometry($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 131071));
      end
      random_words(120);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
